// ----- hdl/bdqs_pkg.sv -----
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared sizes, operation codes and cell control word for the bounded deque.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_DROP_FRONT = 3'd2,
    OP_DROP_BACK = 3'd3,
    OP_SEARCH    = 3'd4
  } bdqs_op_e;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic add_back;
    logic drop_back;
  } bdqs_cmd_t;

endpackage

// ----- hdl/bounded_deque_with_search_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Bounded double-ended queue of words with a membership search over a chain
// of cells; the front entry sits in cell 0.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the input is accepted.
// Throughput: one word per cycle while not stalled; the cell chain shifts and compares at once.
// A waiting result stalls the input only while the output is stalled.
// Reset: rst_ni clears all cell valid bits, the count and the output valid.
module bounded_deque_with_search_unit
  import bdqs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               success_o,
  output logic               full_refused_o,
  output logic [4:0]         entry_count_o
);

  logic [DATA_WIDTH-1:0] key;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DEPTH-1:0]      hit_vec;
  bdqs_cmd_t             cmd;
  bdqs_op_e              op;
  logic                  accept, full, empty, ok, refused;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic                  success_q, refused_q;
  logic [CNT_W-1:0]      out_count_q;

  assign value_ext = {32'd0, value_i};
  assign key       = value_ext[DATA_WIDTH-1:0];
  assign op        = bdqs_op_e'(operation_i);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd     = '0;
    ok      = 1'b0;
    refused = 1'b0;
    count_d = count_q;
    unique case (op)
      OP_ADD_FRONT: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          cmd.shift_right = accept;
          ok              = 1'b1;
          count_d         = count_q + 1'b1;
        end
      end
      OP_ADD_BACK: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          cmd.add_back = accept;
          ok           = 1'b1;
          count_d      = count_q + 1'b1;
        end
      end
      OP_DROP_FRONT: begin
        if (!empty) begin
          cmd.shift_left = accept;
          ok             = 1'b1;
          count_d        = count_q - 1'b1;
        end
      end
      OP_DROP_BACK: begin
        if (!empty) begin
          cmd.drop_back = accept;
          ok            = 1'b1;
          count_d       = count_q - 1'b1;
        end
      end
      OP_SEARCH: begin
        ok = |hit_vec;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;
    logic                  prev_valid, next_valid;
    if (i == 0) begin : g_first
      assign prev_data  = key;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end
    bdqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_i        (key),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .hit_o        (hit_vec[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      success_q   <= ok;
      refused_q   <= refused;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign success_o      = success_q;
  assign full_refused_o = refused_q;
  assign entry_count_o  = 5'(out_count_q);

endmodule

// ----- hdl/bdqs_cell.sv -----
// ----------------------------------------------------------------------------
// bdqs_cell
// One slot of the deque chain: holds a word and its valid bit, shifts with
// its neighbors, claims a back insert or drop, and compares against the key.
// ----------------------------------------------------------------------------
module bdqs_cell
  import bdqs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdqs_cmd_t             cmd_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] prev_data_i,
  input  logic                  prev_valid_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  input  logic                  next_valid_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic                  hit_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.shift_right) begin
      data_d  = prev_data_i;
      valid_d = prev_valid_i;
    end else if (cmd_i.shift_left) begin
      data_d  = next_data_i;
      valid_d = next_valid_i;
    end else if (cmd_i.add_back && prev_valid_i && !valid_q) begin
      data_d  = key_i;
      valid_d = 1'b1;
    end else if (cmd_i.drop_back && valid_q && !next_valid_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign hit_o   = valid_q && (data_q == key_i);

endmodule

// ----- hdl/bdqs_checker.sv -----
// ----------------------------------------------------------------------------
// bdqs_assert
// Port-level checks on the deque results, bound to the top level.
// ----------------------------------------------------------------------------
module bdqs_assert
  import bdqs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               success_o,
  input logic               full_refused_o,
  input logic [4:0]         entry_count_o
);

  a_refused_not_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_refused_o |-> !success_o)
    else $error("refused add reported success");

  a_refused_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_refused_o |-> entry_count_o == 5'(DEPTH))
    else $error("add refused while not full");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= 5'(DEPTH))
    else $error("count beyond depth");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_count_o)
      && $stable(success_o) && $stable(full_refused_o))
    else $error("stalled result changed");

  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word gave no result");

endmodule

bind bounded_deque_with_search_unit bdqs_assert u_bdqs_assert (.*);
